FILE: sv/audio_frame_parser_crc_check_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio frame parser with CRC check
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_PARSER_CRC_CHECK_CORE_DEFINES_SVH
`define AUDIO_FRAME_PARSER_CRC_CHECK_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afp assertion failed");

`endif

FILE: sv/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg
// Types, constants and the CRC-32 byte update shared by the frame parser.
// ----------------------------------------------------------------------------
package afp_pkg;

  localparam int unsigned HDR_LEN  = 19;
  localparam int unsigned CRC_LEN  = 4;
  localparam logic [7:0]  TYPE_MAX = 8'h04;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [15:0] MAGIC_RESET  = 16'hAF01;
  localparam logic [15:0] MAXLEN_RESET = 16'd16384;

  // Register indexes on the configuration port.
  localparam logic REG_MAGIC  = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Frame status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_LEN_LARGE = 3'd4;
  localparam logic [2:0] ST_CRC_BAD   = 3'd5;

  typedef struct packed {
    logic               kind;
    logic [7:0]         payload_byte;
    logic [2:0]         status;
    logic [7:0]         version;
    logic [2:0]         ptype;
    logic [7:0]         flags;
    logic signed [31:0] seq_num;
    logic signed [63:0] ts_val;
    logic [15:0]        length;
  } afp_res_t;

  // Reflected CRC-32 update by one byte, one bit per step.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/afp_parse.sv
// ----------------------------------------------------------------------------
// afp_parse
// Frame state, header capture, CRC update and status verdict for one byte.
// ----------------------------------------------------------------------------
`include "audio_frame_parser_crc_check_core_defines.svh"

module afp_parse #(
  parameter int POSITION_WIDTH = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [15:0]       exp_magic,
  input  logic [15:0]       max_len,
  output logic              res_vld,
  output afp_pkg::afp_res_t res
);
  import afp_pkg::*;

  localparam int PW = POSITION_WIDTH;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   magic_r, magic_nxt;
  logic [7:0]    ver_r, ver_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [63:0]   ts_r, ts_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   rcrc_r, rcrc_nxt;
  logic [2:0]    err_r, err_nxt;

  logic [PW-1:0] pay_end, crc_end;
  logic          in_hdr, in_pay, in_crc, fwd;
  logic [2:0]    status;

  always_comb begin
    magic_nxt = magic_r;
    ver_nxt   = ver_r;
    type_nxt  = type_r;
    flags_nxt = flags_r;
    seq_nxt   = seq_r;
    ts_nxt    = ts_r;
    len_nxt   = len_r;
    if (pos_r < PW'(2)) begin
      magic_nxt = {magic_r[7:0], in_byte};
    end else if (pos_r == PW'(2)) begin
      ver_nxt = in_byte;
    end else if (pos_r == PW'(3)) begin
      type_nxt = in_byte;
    end else if (pos_r == PW'(4)) begin
      flags_nxt = in_byte;
    end else if (pos_r <= PW'(8)) begin
      seq_nxt = {seq_r[23:0], in_byte};
    end else if (pos_r <= PW'(16)) begin
      ts_nxt = {ts_r[55:0], in_byte};
    end else if (pos_r <= PW'(18)) begin
      len_nxt = {len_r[7:0], in_byte};
    end
  end

  // The payload end uses the length as it stands after this byte.
  assign pay_end = PW'(HDR_LEN) + PW'(len_nxt);
  assign crc_end = pay_end + PW'(CRC_LEN);
  assign in_hdr  = pos_r < PW'(HDR_LEN);
  assign in_pay  = !in_hdr && (pos_r < pay_end);
  assign in_crc  = !in_hdr && !in_pay && (pos_r < crc_end);
  assign fwd     = in_pay && (err_r == ST_OK);

  assign crc_nxt  = (in_hdr || in_pay) ? crc32_byte(crc_r, in_byte) : crc_r;
  assign rcrc_nxt = in_crc ? {rcrc_r[23:0], in_byte} : rcrc_r;
  assign pos_nxt  = (pos_r != '1) ? pos_r + PW'(1) : pos_r;

  // The header verdict is taken when the last header byte arrives.
  always_comb begin
    err_nxt = err_r;
    if (pos_r == PW'(HDR_LEN - 1)) begin
      if (magic_nxt != exp_magic) begin
        err_nxt = ST_BAD_MAGIC;
      end else if (type_nxt > TYPE_MAX) begin
        err_nxt = ST_BAD_TYPE;
      end else if (len_nxt > max_len) begin
        err_nxt = ST_LEN_LARGE;
      end
    end
  end

  always_comb begin
    if (pos_nxt < PW'(HDR_LEN + CRC_LEN)) begin
      status = ST_SHORT;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (pos_nxt < crc_end) begin
      status = ST_SHORT;
    end else if (~crc_nxt != rcrc_nxt) begin
      status = ST_CRC_BAD;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res = '0;
    if (in_last) begin
      res.kind    = KIND_SUMMARY;
      res.status  = status;
      res.version = ver_nxt;
      res.ptype   = (type_nxt <= TYPE_MAX) ? type_nxt[2:0] : 3'd0;
      res.flags   = flags_nxt;
      res.seq_num = seq_nxt;
      res.ts_val  = ts_nxt;
      res.length  = len_nxt;
    end else begin
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = in_byte;
    end
  end

  assign res_vld = acc && (in_last || fwd);

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_last)) begin
      pos_r   <= '0;
      magic_r <= '0;
      ver_r   <= '0;
      type_r  <= '0;
      flags_r <= '0;
      seq_r   <= '0;
      ts_r    <= '0;
      len_r   <= '0;
      crc_r   <= CRC_INIT;
      rcrc_r  <= '0;
      err_r   <= ST_OK;
    end else if (acc) begin
      pos_r   <= pos_nxt;
      magic_r <= magic_nxt;
      ver_r   <= ver_nxt;
      type_r  <= type_nxt;
      flags_r <= flags_nxt;
      seq_r   <= seq_nxt;
      ts_r    <= ts_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
      err_r   <= err_nxt;
    end
  end

  `AFP_ASSERT_NXT(a_clear_on_last, clk, rst_n, acc && in_last, pos_r == '0 && err_r == ST_OK)
  `AFP_ASSERT_IMP(a_fwd_only_ok, clk, rst_n, res_vld && !in_last, err_r == ST_OK && !in_hdr)
  `AFP_ASSERT_NXT(a_pos_grows, clk, rst_n, acc && !in_last, pos_r >= $past(pos_r))

endmodule

FILE: sv/afp_skid.sv
// ----------------------------------------------------------------------------
// afp_skid
// Output register with a skid stage, so the input side never waits on the
// receiver combinationally.
// ----------------------------------------------------------------------------
`include "audio_frame_parser_crc_check_core_defines.svh"

module afp_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  afp_pkg::afp_res_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output afp_pkg::afp_res_t out_data
);
  import afp_pkg::*;

  logic     out_valid_r, skid_valid_r;
  afp_res_t out_data_r, skid_data_r;
  logic     take;

  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AFP_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `AFP_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_valid_r && !out_stall, !skid_valid_r)
  `AFP_ASSERT_NXT(a_push_lands, clk, rst_n, push && !skid_valid_r, out_valid_r)

endmodule

FILE: sv/audio_frame_parser_crc_check_core.sv
// ----------------------------------------------------------------------------
// audio_frame_parser_crc_check_core
// Byte-wide deframer for audio link frames with a CRC-32 check.
// ----------------------------------------------------------------------------
// The input channel carries one received byte per item, with in_last_byte
// marking the final byte of the buffer. A frame is a 19-byte big-endian
// header (magic, version, type, flags, sequence, timestamp, payload length),
// the payload, and a big-endian CRC-32 over header and payload.
// Payload bytes of a frame whose header passed its checks come out as items
// of kind payload; the last byte yields one summary item with the header
// fields and a status. Bytes after the CRC are ignored.
// Each byte is processed in the cycle it is accepted; its result is registered
// in the output register or the skid stage, and one byte is taken every cycle
// while in_stall is low. The CRC update and field capture are byte-wide.
// When the receiver stalls, one further result is held in a skid stage and
// in_stall rises only once that stage is full; it is a register output.
// Synchronous reset clears the frame state, drops any held result and sets
// the sync word and the payload length limit to their defaults. The
// configuration registers are meant to be written while no frame is in flight.
// ----------------------------------------------------------------------------
module audio_frame_parser_crc_check_core #(
  parameter int POSITION_WIDTH = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_last_byte,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [7:0]         out_payload_byte,
  output logic [2:0]         out_status,
  output logic [7:0]         out_version_out,
  output logic [2:0]         out_packet_type,
  output logic [7:0]         out_flags_out,
  output logic signed [31:0] out_sequence_out,
  output logic signed [63:0] out_timestamp_out,
  output logic [15:0]        out_payload_length,
  // Configuration port.
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import afp_pkg::*;

  logic [15:0] magic_r;
  logic [15:0] maxlen_r;
  logic        cfg_wr;
  logic        acc;
  logic        res_vld;
  afp_res_t    res;
  afp_res_t    out_data;
  logic        skid_full;

  // Registers sit at byte addresses 0 and 4; bit 2 of the address selects.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r  <= MAGIC_RESET;
      maxlen_r <= MAXLEN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MAGIC:  magic_r  <= cfg_pwdata[15:0];
        REG_MAXLEN: maxlen_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAGIC:  cfg_prdata = {16'd0, magic_r};
      REG_MAXLEN: cfg_prdata = {16'd0, maxlen_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // A byte is taken whenever the skid stage has room.
  assign in_stall = skid_full;
  assign acc      = in_valid && !skid_full;

  afp_parse #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last_byte),
    .exp_magic (magic_r),
    .max_len   (maxlen_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  afp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_kind           = out_data.kind;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_status         = out_data.status;
  assign out_version_out    = out_data.version;
  assign out_packet_type    = out_data.ptype;
  assign out_flags_out      = out_data.flags;
  assign out_sequence_out   = out_data.seq_num;
  assign out_timestamp_out  = out_data.ts_val;
  assign out_payload_length = out_data.length;

endmodule
